>>> design/tfns_pkg.sv
// Shared constants, register indexes and helper functions for the tone and
// filtered-noise synthesizer. No dependencies.
`timescale 1ns / 1ps

package tfns_pkg;

    localparam int PHASE_BITS     = 24;
    localparam int SAMPLE_BITS    = 16;
    localparam int SINE_ADDR_BITS = 10;
    localparam int COEF_FRAC_BITS = 22;

    localparam int STEP_BITS  = PHASE_BITS - 1;
    localparam int GAIN_BITS  = 16;
    localparam int COEF_BITS  = 24;
    localparam int AMP_BITS   = SAMPLE_BITS - 1;
    localparam int SINE_DEPTH = 2 ** SINE_ADDR_BITS;

    // shared multiplier: A takes coefficients (negated too) and samples,
    // B takes gains, tone weights, the noise difference and the filter output history
    localparam int MUL_A_BITS = COEF_BITS + 1;
    localparam int MUL_B_BITS = SAMPLE_BITS + 2;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = PROD_BITS + 3;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COEF_BITS;

    // 0.6 and 0.3 in Q0.16
    localparam logic signed [MUL_B_BITS-1:0] TONE_FUND_GAIN = MUL_B_BITS'(39322);
    localparam logic signed [MUL_B_BITS-1:0] TONE_HARM_GAIN = MUL_B_BITS'(19661);

    localparam logic signed [ACC_BITS-1:0] FILT_HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] MIX_HALF =
        ACC_BITS'(1) << (GAIN_BITS - 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP  = 3'd0,
        CFG_ENGINE_GAIN = 3'd1,
        CFG_SQUEAL_GAIN = 3'd2,
        CFG_COEF_B0     = 3'd3,
        CFG_COEF_A1     = 3'd4,
        CFG_COEF_A2     = 3'd5
    } t_cfg_idx;

    typedef logic [AMP_BITS-1:0] t_sine_rom [SINE_DEPTH];

    // Quarter-wave table, entry k = sin((2k+1)/2^(A+1) * pi/2) at full scale,
    // from a truncating Q30 Taylor series; evaluated at elaboration only.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] one;
        logic [63:0] amp;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        one = 64'd1 << 30;
        amp = (64'd1 << AMP_BITS) - 64'd1;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            x  = ((64'(2 * k) + 64'd1) * 64'd1686629713) >> (SINE_ADDR_BITS + 1);
            x2 = (x * x) >> 30;
            t  = one;
            t  = one - ((x2 * t) >> 30) / 110;
            t  = one - ((x2 * t) >> 30) / 72;
            t  = one - ((x2 * t) >> 30) / 42;
            t  = one - ((x2 * t) >> 30) / 20;
            t  = one - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            e  = (s * amp + (64'd1 << 29)) >> 30;
            if (e > amp) begin
                e = amp;
            end
            rom[k] = e[AMP_BITS-1:0];
        end
        return rom;
    endfunction

    // clamp an accumulator-wide value to the signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        hi = ACC_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
        lo = -hi - ACC_BITS'(1);
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> design/tone_and_filtered_noise_synth.sv
// Tone plus bandpass-filtered noise mixer, one output item per input item.
// Uses tfns_pkg for widths, register indexes, sine table builder and saturation.
//
//  channel    | direction | handshake                     | payload
//  s_axis     | in        | i_s_axis_tvalid/o_s_axis_tready | tdata: noise_sample; tlast: buffer_end
//  m_axis     | out       | o_m_axis_tvalid/i_m_axis_tready | tdata: mixed_sample; tlast: last_of_buffer
//  cfg        | in        | i_cfg_valid/o_cfg_ready       | i_cfg_index, i_cfg_data
//
// One multiplier is shared by seven products (two tone weights, three filter
// taps, two gains), each registered before the accumulator, and the sine ROM
// port is read twice in series.
// Reset is synchronous: phases, filter history, registers and valids clear.
// A result held on m_axis stalls only the final output step of the next item.
// Config writes are taken every cycle.
`timescale 1ns / 1ps

module tone_and_filtered_noise_synth (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // noise_sample [15:0]
    input  logic [15:0]                         i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // mixed_sample [15:0]
    output logic [15:0]                         o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tfns_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tfns_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import tfns_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIN1,
        S_SIN2,
        S_B0,
        S_A1,
        S_A2,
        S_ME,
        S_FILT,
        S_MS,
        S_MIX,
        S_OUT
    } t_state;

    localparam t_sine_rom SineRom = build_sine_rom();

    t_state r_state;

    logic [STEP_BITS-1:0]          r_phase_step;
    logic [GAIN_BITS-1:0]          r_engine_gain;
    logic [GAIN_BITS-1:0]          r_squeal_gain;
    logic signed [COEF_BITS-1:0]   r_coef_b0;
    logic signed [COEF_BITS-1:0]   r_coef_a1;
    logic signed [COEF_BITS-1:0]   r_coef_a2;

    logic [PHASE_BITS-1:0]         r_tone_phase;
    logic [PHASE_BITS-1:0]         r_harm_phase;
    logic signed [SAMPLE_BITS-1:0] r_nd1;
    logic signed [SAMPLE_BITS-1:0] r_nd2;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [SAMPLE_BITS-1:0] r_y2;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] r_tone;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic [AMP_BITS-1:0]           r_rom_q;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;

    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_data;
    logic                          r_out_last;

    logic [PHASE_BITS-1:0]         rd_phase;
    logic [1:0]                    rd_quad;
    logic [SINE_ADDR_BITS-1:0]     rom_addr;
    logic [1:0]                    use_quad;
    logic signed [MUL_A_BITS-1:0]  sine_val;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    tone_sh;
    logic signed [ACC_BITS-1:0]    filt_sh;
    logic signed [ACC_BITS-1:0]    mix_sh;
    logic signed [SAMPLE_BITS-1:0] n_tone;
    logic signed [SAMPLE_BITS-1:0] n_y;
    logic signed [SAMPLE_BITS-1:0] n_mix;
    logic                          out_free;
    logic                          in_accept;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // ROM address: tone phase while idle, harmonic phase in the cycle after
    always_comb begin
        rd_phase = (r_state == S_SIN1) ? r_harm_phase : r_tone_phase;
        rd_quad  = rd_phase[PHASE_BITS-1 -: 2];
        rom_addr = rd_phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
        if (rd_quad[0]) begin
            rom_addr = ~rom_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= SineRom[rom_addr];
    end

    always_comb begin
        use_quad = (r_state == S_SIN2) ? r_harm_phase[PHASE_BITS-1 -: 2]
                                       : r_tone_phase[PHASE_BITS-1 -: 2];
        sine_val = MUL_A_BITS'(r_rom_q);
        if (use_quad[1]) begin
            sine_val = -sine_val;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SIN1, S_SIN2: begin
                mul_a = sine_val;
                mul_b = (r_state == S_SIN1) ? TONE_FUND_GAIN : TONE_HARM_GAIN;
            end
            S_B0: begin
                mul_a = MUL_A_BITS'(r_coef_b0);
                mul_b = MUL_B_BITS'(r_x) - MUL_B_BITS'(r_nd2);
            end
            S_A1: begin
                mul_a = -MUL_A_BITS'(r_coef_a1);
                mul_b = MUL_B_BITS'(r_y1);
            end
            S_A2: begin
                mul_a = -MUL_A_BITS'(r_coef_a2);
                mul_b = MUL_B_BITS'(r_y2);
            end
            S_ME: begin
                mul_a = MUL_A_BITS'(r_tone);
                mul_b = MUL_B_BITS'({1'b0, r_engine_gain});
            end
            S_MS: begin
                mul_a = MUL_A_BITS'(r_y);
                mul_b = MUL_B_BITS'({1'b0, r_squeal_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prod_ext = ACC_BITS'(r_prod);
        tone_sh  = (r_acc + MIX_HALF) >>> GAIN_BITS;
        filt_sh  = (r_acc + FILT_HALF) >>> COEF_FRAC_BITS;
        mix_sh   = (r_acc + MIX_HALF) >>> GAIN_BITS;
        // tone magnitude stays below 0.9 of full scale, no clamp needed
        n_tone   = tone_sh[SAMPLE_BITS-1:0];
        n_y      = sat_sample(filt_sh);
        n_mix    = sat_sample(mix_sh);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_phase_step  <= '0;
            r_engine_gain <= '0;
            r_squeal_gain <= '0;
            r_coef_b0     <= '0;
            r_coef_a1     <= '0;
            r_coef_a2     <= '0;
            r_tone_phase  <= '0;
            r_harm_phase  <= '0;
            r_nd1         <= '0;
            r_nd2         <= '0;
            r_y1          <= '0;
            r_y2          <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[STEP_BITS-1:0];
                    CFG_ENGINE_GAIN: r_engine_gain <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_SQUEAL_GAIN: r_squeal_gain <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_COEF_B0:     r_coef_b0     <= i_cfg_data[COEF_BITS-1:0];
                    CFG_COEF_A1:     r_coef_a1     <= i_cfg_data[COEF_BITS-1:0];
                    CFG_COEF_A2:     r_coef_a2     <= i_cfg_data[COEF_BITS-1:0];
                    default: ;
                endcase
            end

            // the output step reloads the valid itself
            if (r_out_valid && i_m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            // each accumulating state consumes the product started in the state before
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_x     <= i_s_axis_tdata;
                        r_last  <= i_s_axis_tlast;
                        r_state <= S_SIN1;
                    end
                end
                S_SIN1: r_state <= S_SIN2;
                S_SIN2: begin
                    r_acc   <= prod_ext;
                    r_state <= S_B0;
                end
                S_B0: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_tone  <= n_tone;
                    r_acc   <= prod_ext;
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_ME;
                end
                S_ME: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    r_y     <= n_y;
                    r_y1    <= n_y;
                    r_y2    <= r_y1;
                    r_nd1   <= r_x;
                    r_nd2   <= r_nd1;
                    r_acc   <= prod_ext;
                    r_state <= S_MS;
                end
                S_MS: r_state <= S_MIX;
                S_MIX: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= n_mix;
                        r_out_last   <= r_last;
                        r_tone_phase <= r_tone_phase + PHASE_BITS'(r_phase_step);
                        r_harm_phase <= r_harm_phase +
                                        PHASE_BITS'({r_phase_step, 1'b0});
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SIN1))
        else $error("accepted item did not start the sequence");

    a_phase_moves_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_tone_phase)) |-> ($past(r_state) == S_OUT))
        else $error("tone phase changed outside the output step");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_m_axis_tvalid && r_state == S_IDLE))
        else $error("finished item not presented on the output");

    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILT) |=> (r_nd1 == r_x && r_y1 == r_y))
        else $error("filter history out of step");
`endif

endmodule
